// ===== hdl/overwrite_oldest_packet_ring_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet ring
// Concurrent checks that can be compiled out by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_OLDEST_PACKET_RING_TOP_ASSERT_SVH
`define OVERWRITE_OLDEST_PACKET_RING_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define OOPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define OOPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define OOPR_ASSERT(lbl, clk, rst_n, prop, msg)

`define OOPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/oopr_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet ring package
// Shared constants, codes and structures of the packet ring.
// ----------------------------------------------------------------------------
package oopr_pkg;

  localparam int unsigned SlotsDefault    = 16;
  localparam int unsigned MaxBytesDefault = 64;
  localparam int unsigned LenW            = 7;
  localparam int unsigned CmdDepth        = 2;
  localparam int unsigned ResDepth        = 4;

  typedef enum logic {
    OpWrite = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic            last;
    logic            empty;
  } res_t;

  typedef struct packed {
    logic room;
    logic full;
  } resq_st_t;

endpackage

// ===== hdl/oopr_front.sv =====
// ----------------------------------------------------------------------------
// Packet ring front end
// Accepts input transactions, classifies them and queues the commands.
// ----------------------------------------------------------------------------
module oopr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               operation_i,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output oopr_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i
);

  localparam int unsigned PtrW = (oopr_pkg::CmdDepth > 1) ? $clog2(oopr_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(oopr_pkg::CmdDepth + 1);

  oopr_pkg::cmd_t store_q [oopr_pkg::CmdDepth];
  oopr_pkg::cmd_t cmd_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push_ok;

  always_comb begin
    cmd_in.op   = oopr_pkg::op_e'(operation_i);
    cmd_in.data = data_byte_i;
    cmd_in.last = final_byte_i;
  end

  assign full_o      = (count_q == CntW'(oopr_pkg::CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = store_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(oopr_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(oopr_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push_ok, cmd_pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hdl/oopr_back.sv =====
// ----------------------------------------------------------------------------
// Packet ring back end
// Executes queued commands against the slot ring and streams packets out.
// ----------------------------------------------------------------------------
module oopr_back #(
  parameter int unsigned SLOTS            = oopr_pkg::SlotsDefault,
  parameter int unsigned MAX_PACKET_BYTES = oopr_pkg::MaxBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  oopr_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  logic           room_i,
  output oopr_pkg::res_t res_o
);

  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned LW    = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned Depth = SLOTS * MAX_PACKET_BYTES;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StStream = 2'b10
  } state_e;

  logic [7:0]    byte_mem [Depth];
  logic [LW-1:0] len_mem  [SLOTS];

  state_e        state_q, state_d;
  logic [SW-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic [CW-1:0] count_q, count_d;
  logic          wip_q, wip_d;
  logic [LW-1:0] off_q, off_d, idx_q, idx_d;
  logic          s2_valid_q, s2_valid_d, s2_last_q, s2_last_d, s2_empty_q, s2_empty_d;
  logic [LW-1:0] s2_len_q, s2_len_d;
  logic [7:0]    rdata_q;
  logic [LW-1:0] len_rd_q;

  logic [SW+1:0] slot_sum, slot_wrap;
  logic [SW-1:0] wr_slot, oldest_next;
  logic [LW-1:0] wr_off;
  logic          start, full_ring, wr_ok, do_write, completed_nz, last_byte;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    full_ring    = (count_q == CW'(SLOTS));
    start        = !wip_q;
    slot_sum     = (SW+2)'(oldest_q) + (SW+2)'(count_q);
    slot_wrap    = (slot_sum >= (SW+2)'(SLOTS)) ? slot_sum - (SW+2)'(SLOTS) : slot_sum;
    oldest_next  = (oldest_q == SW'(SLOTS - 1)) ? '0 : oldest_q + SW'(1);
    wr_slot      = start ? (full_ring ? oldest_q : SW'(slot_wrap)) : newest_q;
    wr_off       = start ? '0 : off_q;
    wr_ok        = (wr_off < LW'(MAX_PACKET_BYTES));
    wr_addr      = AW'(wr_slot) * AW'(MAX_PACKET_BYTES) + AW'(wr_off);
    rd_addr      = AW'(oldest_q) * AW'(MAX_PACKET_BYTES) + AW'(idx_q);
    completed_nz = (count_q > CW'(wip_q));
    last_byte    = ((idx_q + LW'(1)) == len_rd_q);
  end

  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    newest_d   = newest_q;
    count_d    = count_q;
    wip_d      = wip_q;
    off_d      = off_q;
    idx_d      = idx_q;
    s2_valid_d = 1'b0;
    s2_len_d   = '0;
    s2_last_d  = 1'b0;
    s2_empty_d = 1'b0;
    do_write   = 1'b0;
    cmd_pop_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == oopr_pkg::OpWrite) begin
            cmd_pop_o = 1'b1;
            do_write  = 1'b1;
            if (start) begin
              newest_d = wr_slot;
              wip_d    = 1'b1;
              if (full_ring) begin
                oldest_d = oldest_next;
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            off_d = wr_ok ? wr_off + LW'(1) : wr_off;
            if (cmd_i.last) begin
              wip_d = 1'b0;
            end
          end else if (completed_nz) begin
            cmd_pop_o = 1'b1;
            idx_d     = '0;
            state_d   = StStream;
          end else if (room_i) begin
            cmd_pop_o  = 1'b1;
            s2_valid_d = 1'b1;
            s2_last_d  = 1'b1;
            s2_empty_d = 1'b1;
          end
        end
      end
      StStream: begin
        if (room_i) begin
          s2_valid_d = 1'b1;
          s2_len_d   = len_rd_q;
          s2_last_d  = last_byte;
          idx_d      = idx_q + LW'(1);
          if (last_byte) begin
            idx_d    = '0;
            oldest_d = oldest_next;
            count_d  = count_q - CW'(1);
            state_d  = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      oldest_q   <= '0;
      newest_q   <= '0;
      count_q    <= '0;
      wip_q      <= 1'b0;
      off_q      <= '0;
      idx_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      oldest_q   <= oldest_d;
      newest_q   <= newest_d;
      count_q    <= count_d;
      wip_q      <= wip_d;
      off_q      <= off_d;
      idx_q      <= idx_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_len_q   <= s2_len_d;
    s2_last_q  <= s2_last_d;
    s2_empty_q <= s2_empty_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_write && wr_ok) begin
      byte_mem[wr_addr] <= cmd_i.data;
    end
    rdata_q <= byte_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (do_write && wr_ok) begin
      len_mem[wr_slot] <= wr_off + LW'(1);
    end
    len_rd_q <= len_mem[oldest_q];
  end

  always_comb begin
    res_o.valid = s2_valid_q;
    res_o.data  = s2_empty_q ? 8'h00 : rdata_q;
    res_o.len   = oopr_pkg::LenW'(s2_len_q);
    res_o.last  = s2_last_q;
    res_o.empty = s2_empty_q;
  end

endmodule

// ===== hdl/oopr_resq.sv =====
// ----------------------------------------------------------------------------
// Packet ring result queue
// Holds finished results until the consumer takes them.
// ----------------------------------------------------------------------------
module oopr_resq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  oopr_pkg::res_t                   res_i,
  output oopr_pkg::resq_st_t               st_o,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic [7:0]                       out_byte_o,
  output logic [oopr_pkg::LenW-1:0]        packet_length_o,
  output logic                             last_of_run_o,
  output logic                             ring_empty_o
);

  localparam int unsigned PtrW = $clog2(oopr_pkg::ResDepth);
  localparam int unsigned CntW = $clog2(oopr_pkg::ResDepth + 1);

  oopr_pkg::res_t  store_q [oopr_pkg::ResDepth];
  oopr_pkg::res_t  head;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop_ok;

  assign empty_o         = (count_q == '0);
  assign pop_ok          = pop_i && !empty_o;
  assign head            = store_q[rd_ptr_q];
  assign out_byte_o      = head.data;
  assign packet_length_o = head.len;
  assign last_of_run_o   = head.last;
  assign ring_empty_o    = head.empty;

  always_comb begin
    st_o.full = (count_q == CntW'(oopr_pkg::ResDepth));
    st_o.room = ((CntW+1)'(count_q) + (CntW+1)'(res_i.valid)) < (CntW+1)'(oopr_pkg::ResDepth);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (res_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(oopr_pkg::ResDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(oopr_pkg::ResDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({res_i.valid, pop_ok})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      store_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== hdl/overwrite_oldest_packet_ring_top.sv =====
// ----------------------------------------------------------------------------
// Overwrite-oldest packet ring
// A ring of SLOTS packet slots of up to MAX_PACKET_BYTES bytes each. A write
// transaction stores one byte unless its packet is full; the first byte of a
// packet claims the next slot and drops the oldest packet when all slots are
// taken. A read transaction of a stored packet of L bytes occupies the back
// end for a start step, then one byte per cycle while the result queue has
// room, from the single read port of the byte store; its first byte passes
// the stream state and the registered output stage on its way to the result
// queue. A read that finds no completed packet returns one result with
// ring_empty set. A two-entry command queue and a four-entry result queue let
// input and output stall independently. The byte store and the slot length
// store need no clearing after reset; only slots that hold a packet are read.
// ----------------------------------------------------------------------------
module overwrite_oldest_packet_ring_top #(
  parameter int unsigned SLOTS            = oopr_pkg::SlotsDefault,
  parameter int unsigned MAX_PACKET_BYTES = oopr_pkg::MaxBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic                      operation_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      final_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                out_byte_o,
  output logic [oopr_pkg::LenW-1:0] packet_length_o,
  output logic                      last_of_run_o,
  output logic                      ring_empty_o
);

  `include "overwrite_oldest_packet_ring_top_assert.svh"

  oopr_pkg::cmd_t     cmd;
  logic               cmd_valid;
  logic               cmd_pop;
  oopr_pkg::res_t     res;
  oopr_pkg::resq_st_t res_st;

  oopr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  oopr_back #(
    .SLOTS            (SLOTS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .room_i      (res_st.room),
    .res_o       (res)
  );

  oopr_resq u_resq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_i           (res),
    .st_o            (res_st),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .packet_length_o (packet_length_o),
    .last_of_run_o   (last_of_run_o),
    .ring_empty_o    (ring_empty_o)
  );

  `OOPR_ASSERT(a_cmd_pop_valid, clk_i, rst_ni, cmd_pop |-> cmd_valid, "command popped from empty queue")
  `OOPR_ASSERT_NEVER(a_res_overflow, clk_i, rst_ni, res.valid && res_st.full, "result queue overflow")
  `OOPR_ASSERT(a_empty_shape, clk_i, rst_ni, (!empty && ring_empty_o) |-> (last_of_run_o && packet_length_o == '0), "malformed empty result")
  `OOPR_ASSERT(a_len_nonzero, clk_i, rst_ni, (!empty && !ring_empty_o) |-> (packet_length_o != '0), "packet result with zero length")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the overwrite-oldest packet ring
// Writes packets byte by byte and reads them back through the two queue-like
// ports. A directed table covers empty reads, single-byte packets, data
// extremes and a read during a write. Random traffic follows, including
// oversized packets, runs that wrap a full ring, stray writes and a long
// receiver hold-off. Every result is checked in order, against its table row or
// a behavioral model of the ring kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SLOTS = oopr_pkg::SlotsDefault;
  localparam int unsigned MAXB  = oopr_pkg::MaxBytesDefault;

  typedef struct packed {
    logic [7:0]                data;
    logic [oopr_pkg::LenW-1:0] len;
    logic                      fin;
    logic                      none;
  } ring_result_t;

  typedef struct packed {
    oopr_pkg::op_e op;
    logic [7:0]    data;
    logic          fin;
    logic          typed;
    ring_result_t  want;
  } stim_row_t;

  typedef enum int {
    RunRing,
    RunLong,
    RunShort,
    RunRead,
    RunStray
  } run_kind_e;

  localparam int unsigned NumRows = 21;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic                      operation_i;
  logic [7:0]                data_byte_i;
  logic                      final_byte_i;
  logic                      empty;
  logic                      pop;
  logic [7:0]                out_byte_o;
  logic [oopr_pkg::LenW-1:0] packet_length_o;
  logic                      last_of_run_o;
  logic                      ring_empty_o;

  logic [7:0]                pkt_mem [SLOTS*MAXB];
  logic [oopr_pkg::LenW-1:0] slot_len [SLOTS];
  int unsigned     head_slot;
  int unsigned     tail_slot;
  int unsigned     held_pkts;
  int unsigned     fill_offset;
  bit              filling;

  ring_result_t    read_results [$];
  ring_result_t    expected_out [$];
  stim_row_t       directed_rows [NumRows];

  int unsigned     items_sent;
  int unsigned     mismatches;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  bit              hold_request;
  bit              rx_hold;

  overwrite_oldest_packet_ring_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .data_byte_i     (data_byte_i),
    .final_byte_i    (final_byte_i),
    .empty           (empty),
    .pop             (pop),
    .out_byte_o      (out_byte_o),
    .packet_length_o (packet_length_o),
    .last_of_run_o   (last_of_run_o),
    .ring_empty_o    (ring_empty_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic drop_head_packet();
    slot_len[head_slot] = '0;
    head_slot = (head_slot + 1) % SLOTS;
    held_pkts--;
  endtask

  // Updates the ring model for one transaction and leaves the bytes that a
  // read returns in read_results.
  task automatic predict_ring_results(input oopr_pkg::op_e op, input logic [7:0] value,
                                      input logic fin);
    int unsigned done_pkts;
    int unsigned len;
    ring_result_t res;
    read_results.delete();
    if (op == oopr_pkg::OpWrite) begin
      if (!filling) begin
        if (held_pkts >= SLOTS) drop_head_packet();
        tail_slot = (head_slot + held_pkts) % SLOTS;
        slot_len[tail_slot] = '0;
        held_pkts++;
        fill_offset = 0;
        filling = 1'b1;
      end
      if (fill_offset < MAXB) begin
        pkt_mem[tail_slot*MAXB + fill_offset] = value;
        fill_offset++;
        slot_len[tail_slot] = oopr_pkg::LenW'(fill_offset);
      end
      if (fin) filling = 1'b0;
    end else begin
      done_pkts = held_pkts - (filling ? 1 : 0);
      if (done_pkts == 0) begin
        res = '{data: 8'h00, len: '0, fin: 1'b1, none: 1'b1};
        read_results.push_back(res);
      end else begin
        len = slot_len[head_slot];
        for (int unsigned i = 0; i < len; i++) begin
          res.data = pkt_mem[head_slot*MAXB + i];
          res.len  = oopr_pkg::LenW'(len);
          res.fin  = (i + 1 == len);
          res.none = 1'b0;
          read_results.push_back(res);
        end
        drop_head_packet();
      end
    end
  endtask

  task automatic send_item(input oopr_pkg::op_e op, input logic [7:0] value,
                           input logic fin, input logic typed,
                           input ring_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    operation_i  <= op;
    data_byte_i  <= value;
    final_byte_i <= fin;
    forever begin
      @(posedge clk_i);
      if (!full) break;
      @(negedge clk_i);
    end
    predict_ring_results(op, value, fin);
    if (typed) begin
      expected_out.push_back(want);
    end else begin
      foreach (read_results[i]) expected_out.push_back(read_results[i]);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_write(input logic fin);
    send_item(oopr_pkg::OpWrite, 8'($urandom_range(255)), fin, 1'b0, '0);
  endtask

  task automatic send_read();
    send_item(oopr_pkg::OpRead, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  // Packets may be interrupted by reads, which must not see the open packet.
  task automatic send_packet(input int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(99) < 6) send_read();
      send_write(k == len - 1);
    end
  endtask

  function automatic run_kind_e pick_run();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return RunRing;
    if (r < 9) return RunLong;
    if (r < 58) return RunShort;
    if (r < 88) return RunRead;
    return RunStray;
  endfunction

  task automatic random_phase(input int unsigned budget, input run_kind_e first_run);
    int unsigned start;
    run_kind_e kind;
    bit first;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < budget) begin
      kind = first ? first_run : pick_run();
      first = 1'b0;
      case (kind)
        RunRing: begin
          repeat (SLOTS + $urandom_range(1, 4)) send_packet($urandom_range(1, 2));
          repeat ($urandom_range(2, 6)) send_read();
        end
        RunLong: begin
          send_packet($urandom_range(MAXB - 2, MAXB + 6));
          send_read();
        end
        RunShort: send_packet($urandom_range(1, 6));
        RunRead:  send_read();
        default:  send_write(1'($urandom_range(1)));
      endcase
    end
  endtask

  task automatic note_mismatch(input ring_result_t want, input ring_result_t got,
                               input bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) begin
        $display("%0t: unexpected result data=%h len=%0d last=%b empty=%b",
                 $realtime, got.data, got.len, got.fin, got.none);
      end else begin
        $write("%0t: expected data=%h len=%0d last=%b empty=%b",
               $realtime, want.data, want.len, want.fin, want.none);
        $display(", got data=%h len=%0d last=%b empty=%b",
                 got.data, got.len, got.fin, got.none);
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    ring_result_t got;
    ring_result_t want;
    if (rst_ni && pop && !empty) begin
      got.data = out_byte_o;
      got.len  = packet_length_o;
      got.fin  = last_of_run_o;
      got.none = ring_empty_o;
      if (expected_out.size() == 0) begin
        note_mismatch(got, got, 1'b1);
      end else begin
        want = expected_out.pop_front();
        if (got.data !== want.data || got.len !== want.len ||
            got.fin !== want.fin || got.none !== want.none) begin
          note_mismatch(want, got, 1'b0);
        end
      end
    end
  end

  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    rx_hold = 1'b0;
    wait (hold_request);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    operation_i  = oopr_pkg::OpWrite;
    data_byte_i  = 8'h00;
    final_byte_i = 1'b0;
    tx_idle_pct  = 28;
    rx_idle_pct  = 83;
    hold_request = 1'b0;
    items_sent   = 0;
    mismatches   = 0;
    head_slot    = 0;
    tail_slot    = 0;
    held_pkts    = 0;
    fill_offset  = 0;
    filling      = 1'b0;
    foreach (slot_len[i]) slot_len[i] = '0;

    directed_rows = '{
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b1}},
      '{oopr_pkg::OpWrite, 8'hFF, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'hFF, 7'd1, 1'b1, 1'b0}},
      '{oopr_pkg::OpRead,  8'hFF, 1'b1, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b1}},
      '{oopr_pkg::OpWrite, 8'h00, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'h00, 7'd1, 1'b1, 1'b0}},
      '{oopr_pkg::OpWrite, 8'h55, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b1}},
      '{oopr_pkg::OpWrite, 8'hAA, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpWrite, 8'h01, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpWrite, 8'h80, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpWrite, 8'h7F, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpWrite, 8'h0F, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpWrite, 8'hF0, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'h00, 7'd0, 1'b1, 1'b1}},
      '{oopr_pkg::OpWrite, 8'h33, 1'b1, 1'b0, '0},
      '{oopr_pkg::OpRead,  8'h00, 1'b0, 1'b1, '{8'h33, 7'd1, 1'b1, 1'b0}}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].fin,
                directed_rows[i].typed, directed_rows[i].want);
    end
    random_phase(80, RunRing);

    tx_idle_pct = 83;
    rx_idle_pct = 28;
    random_phase(80, RunLong);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    random_phase(80, RunShort);
    push <= 1'b0;

    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
